@@ hw/rtl/xxrf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package xxrf_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam int BYTE_W      = 8;
  localparam int LIMIT_W     = 4;
  localparam int FILL_W      = 4;
  localparam int CFG_INDEX_W = 2;

  localparam logic [LIMIT_W-1:0] UPPER_RESET = 4'd4;
  localparam logic [LIMIT_W-1:0] LOWER_RESET = 4'd1;

  // Bytes below this code are control codes, line feed excepted.
  localparam logic [BYTE_W-1:0] CTRL_BELOW = 8'd32;
  localparam logic [BYTE_W-1:0] LINE_FEED  = 8'd10;

  // Item commands.
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_CONSUME = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_UPPER = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOWER = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STORE,
    ST_READ,
    ST_CHECK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_item;
    logic do_store;
    logic do_pop;
    logic load_result;
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_consume;
    logic empty;
    logic pop_more;
    logic result_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

@@ hw/rtl/xxrf_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface xxrf_item_if;
  import xxrf_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink (input valid, command, rx_byte, output ready);
endinterface

interface xxrf_result_if;
  import xxrf_pkg::*;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic              overflow;
  logic              data_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              xoff_request;
  logic              xon_request;
  logic [FILL_W-1:0] fill_level;

  modport source (
    output valid, accepted, overflow, data_valid, out_byte, xoff_request, xon_request,
    fill_level,
    input ready
  );
  modport sink (
    input valid, accepted, overflow, data_valid, out_byte, xoff_request, xon_request,
    fill_level,
    output ready
  );
endinterface

interface xxrf_cfg_if;
  import xxrf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [LIMIT_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/xon_xoff_receive_fifo_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Receive byte buffer with XON/XOFF flow control.
// The item channel carries a command and a byte: a store appends the byte at
// the tail unless the block is paused or full; a consume pops bytes, passing
// over control codes other than line feed, until a kept byte or an empty
// buffer. Each item gives exactly one transfer on the result channel, which
// reports the popped byte, the store outcome, the XOFF/XON requests and the
// fill level after the item. The cfg channel writes the upper and lower
// limits and is always ready; the user must write it only while the block
// is idle, as the block itself does not enforce this. Rate: one item at a
// time. A store passes through STORE and FINISH; a consume passes through
// READ and CHECK for each byte popped, then FINISH, or goes straight to
// FINISH when the buffer is empty. The result is registered in FINISH. Each
// pop spends the READ step on the registered read of the byte RAM and the
// CHECK step on the check, so a consume may pop up to DEPTH bytes. A stalled
// result only holds the block at its final step.
// Reset clears the indices, the fill count, the pause flag and the result
// valid, and loads the limits with 4 and 1; the byte RAM is not cleared.
module xon_xoff_receive_fifo_unit
  import xxrf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input wire logic       clk,
  input wire logic       rst,
  xxrf_item_if.sink      item,
  xxrf_result_if.source  result,
  xxrf_cfg_if.sink       cfg
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg.ready = 1'b1;

  xxrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item.valid),
    .item_ready(item.ready),
    .status    (status),
    .cmd       (cmd)
  );

  xxrf_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .item_command    (item.command),
    .item_rx_byte    (item.rx_byte),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .res_ready       (result.ready),
    .res_valid       (result.valid),
    .res_accepted    (result.accepted),
    .res_overflow    (result.overflow),
    .res_data_valid  (result.data_valid),
    .res_out_byte    (result.out_byte),
    .res_xoff_request(result.xoff_request),
    .res_xon_request (result.xon_request),
    .res_fill_level  (result.fill_level)
  );

  // After a transfer in, the block is busy with that item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> !item.ready)
    else $error("item taken while the previous one is still being worked on");

  // A result is loaded only when the output register is free.
  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> status.result_free)
    else $error("result register loaded while holding an untaken result");

  // A store outcome and a popped byte never appear in the same result.
  a_store_pop_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.data_valid && (result.accepted || result.overflow)))
    else $error("result mixes store and consume outcomes");

  // One item never asks for both XOFF and XON.
  a_xon_xoff_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.xoff_request && result.xon_request))
    else $error("XOFF and XON requested by one item");

endmodule

`default_nettype wire

@@ hw/rtl/xxrf_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xxrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/xxrf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xxrf_ctrl
  import xxrf_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         item_valid,
  output logic              item_ready,
  input  wire ctrl_status_t status,
  output ctrl_cmd_t         cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_item = 1'b1;
          if (!status.item_consume) begin
            state_next = ST_STORE;
          end else if (status.empty) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_STORE: begin
        cmd.do_store = 1'b1;
        state_next   = ST_FINISH;
      end
      // The RAM read data is registered, so it turns up in the cycle after the address.
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.do_pop = 1'b1;
        state_next = status.pop_more ? ST_READ : ST_FINISH;
      end
      ST_FINISH: begin
        if (status.result_free) begin
          cmd.load_result = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/xxrf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module xxrf_datapath
  import xxrf_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire ctrl_cmd_t              cmd,
  output ctrl_status_t                status,
  input  wire logic                   item_command,
  input  wire logic [BYTE_W-1:0]      item_rx_byte,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [LIMIT_W-1:0]     cfg_data,
  input  wire logic                   res_ready,
  output logic                        res_valid,
  output logic                        res_accepted,
  output logic                        res_overflow,
  output logic                        res_data_valid,
  output logic      [BYTE_W-1:0]      res_out_byte,
  output logic                        res_xoff_request,
  output logic                        res_xon_request,
  output logic      [FILL_W-1:0]      res_fill_level
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  logic [IDX_W-1:0]   read_index;
  logic [IDX_W-1:0]   write_index;
  logic [CNT_W-1:0]   held_count;
  logic               paused;
  logic [LIMIT_W-1:0] upper_limit;
  logic [LIMIT_W-1:0] lower_limit;
  logic [BYTE_W-1:0]  item_byte;

  logic               stage_accepted;
  logic               stage_overflow;
  logic               stage_data_valid;
  logic [BYTE_W-1:0]  stage_out_byte;
  logic               stage_xoff;
  logic               stage_xon;

  logic [BYTE_W-1:0]  rdata;
  logic               full;
  logic               ram_we;
  logic               byte_kept;
  logic [CMP_W-1:0]   count_wide;
  logic [CMP_W-1:0]   count_after_store;
  logic [CMP_W-1:0]   count_after_pop;

  function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign full              = (held_count == CNT_W'(DEPTH));
  assign count_wide        = CMP_W'(held_count);
  assign count_after_store = full ? count_wide : count_wide + 1'b1;
  assign count_after_pop   = count_wide - 1'b1;
  assign ram_we            = cmd.do_store && !paused && !full;
  assign byte_kept         = (rdata >= CTRL_BELOW) || (rdata == LINE_FEED);

  assign status.item_consume = (item_command == CMD_CONSUME);
  assign status.empty        = (held_count == '0);
  assign status.pop_more     = !byte_kept && (held_count > CNT_W'(1));
  assign status.result_free  = !res_valid || res_ready;

  xxrf_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_index),
    .wdata(item_byte),
    .raddr(read_index),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_index  <= '0;
      write_index <= '0;
      held_count  <= '0;
      paused      <= 1'b0;
      upper_limit <= UPPER_RESET;
      lower_limit <= LOWER_RESET;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_UPPER: upper_limit <= cfg_data;
          CFG_LOWER: lower_limit <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.do_store && !paused) begin
        if (!full) begin
          write_index <= next_index(write_index);
          held_count  <= held_count + 1'b1;
        end
        if (count_after_store > CMP_W'(upper_limit)) begin
          paused <= 1'b1;
        end
      end
      if (cmd.do_pop) begin
        read_index <= next_index(read_index);
        held_count <= held_count - 1'b1;
        // The resume check runs once, on the last pop of the item.
        if (!status.pop_more && paused && (count_after_pop < CMP_W'(lower_limit))) begin
          paused <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_byte        <= item_rx_byte;
      stage_accepted   <= 1'b0;
      stage_overflow   <= 1'b0;
      stage_data_valid <= 1'b0;
      stage_out_byte   <= '0;
      stage_xoff       <= 1'b0;
      stage_xon        <= 1'b0;
    end
    if (cmd.do_store && !paused) begin
      stage_accepted <= !full;
      stage_overflow <= full;
      stage_xoff     <= (count_after_store > CMP_W'(upper_limit));
    end
    if (cmd.do_pop) begin
      stage_data_valid <= 1'b1;
      stage_out_byte   <= rdata;
      stage_xon        <= !status.pop_more && paused
                          && (count_after_pop < CMP_W'(lower_limit));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_result) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_accepted     <= stage_accepted;
      res_overflow     <= stage_overflow;
      res_data_valid   <= stage_data_valid;
      res_out_byte     <= stage_out_byte;
      res_xoff_request <= stage_xoff;
      res_xon_request  <= stage_xon;
      res_fill_level   <= count_wide[FILL_W-1:0];
    end
  end

endmodule

`default_nettype wire
